/* hdl/mudf_pkg.sv */
`default_nettype none

package mudf_pkg;

    // ring and length limits
    localparam int BUF_DEPTH  = 16384;
    localparam int ADDR_W     = $clog2(BUF_DEPTH);
    localparam int MAX_DIGITS = 10;
    localparam int DIG_W      = $clog2(MAX_DIGITS + 1);
    localparam int LEN_W      = 31;
    localparam int HDR_LEN    = 8;
    localparam int HPOS_W     = $clog2(HDR_LEN);

    localparam logic [LEN_W-1:0] LEN_SAT = {LEN_W{1'b1}};

    // command codes
    typedef enum logic [1:0] {
        CMD_RX    = 2'd0,
        CMD_POP   = 2'd1,
        CMD_ACK   = 2'd2,
        CMD_FLUSH = 2'd3
    } cmd_t;

    // parser phases
    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_HEADER,
        PH_SKIP_ID,
        PH_READ_LEN,
        PH_READ_DATA
    } phase_t;

    // characters of interest
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    // header patterns, first character in the top byte
    // index 0 tcp data, 1 read data, 2 push notice
    localparam logic [2:0][HDR_LEN*8-1:0] HDR_TAB = {"MIPPUSH:", "MIPREAD:", "MIPRTCP:"};

    // payload write request from the parser
    typedef struct packed {
        logic       en;
        logic [7:0] data;
    } wr_req_t;

    // flags after the current word
    typedef struct packed {
        logic pending;
        logic push;
    } flags_t;

    // ring pointer advance with wrap
    function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
        logic [ADDR_W-1:0] r;
        if (p == ADDR_W'(BUF_DEPTH - 1))
            r = '0;
        else
            r = p + ADDR_W'(1);
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/mudf_if.sv */
`default_nettype none

// command channel
interface mudf_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] rx_byte;

    modport source (output valid, output cmd, output rx_byte, input ready);
    modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

// result channel
interface mudf_rsp_if;
    logic       valid;
    logic       ready;
    logic       pop_valid;
    logic [7:0] pop_byte;
    logic       payload_pending;
    logic       read_request_needed;

    modport source (output valid, output pop_valid, output pop_byte,
                    output payload_pending, output read_request_needed, input ready);
    modport sink   (input valid, input pop_valid, input pop_byte,
                    input payload_pending, input read_request_needed, output ready);
endinterface

`default_nettype wire

/* hdl/mudf_ram.sv */
`default_nettype none

module mudf_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hdl/mudf_parser.sv */
`default_nettype none

module mudf_parser (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            take,
    input  wire logic [1:0]      cmd,
    input  wire logic [7:0]      rx_byte,
    output mudf_pkg::wr_req_t    wr,
    output mudf_pkg::flags_t     flags
);

    mudf_pkg::phase_t                phase_reg, phase_next;
    logic [mudf_pkg::HPOS_W-1:0]     hpos_reg, hpos_next;
    logic [2:0]                      match_reg, match_next;
    logic [mudf_pkg::LEN_W-1:0]      len_reg, len_next;
    logic [mudf_pkg::DIG_W-1:0]      dig_reg, dig_next;
    logic                            pend_reg, pend_next;
    logic                            push_reg, push_next;

    logic                            rx_take;
    logic                            hdr_last;
    logic [2:0]                      match_now;
    logic                            is_term;
    logic                            is_digit;
    logic [mudf_pkg::LEN_W+3:0]      len_x10;
    logic [mudf_pkg::LEN_W-1:0]      len_acc;
    logic [mudf_pkg::LEN_W-1:0]      len_dec;

    assign rx_take  = take && (cmd == mudf_pkg::CMD_RX);
    assign hdr_last = (hpos_reg == mudf_pkg::HPOS_W'(mudf_pkg::HDR_LEN - 1));
    assign is_term  = (rx_byte == mudf_pkg::CH_COMMA) || (rx_byte == mudf_pkg::CH_CR)
                   || (rx_byte == mudf_pkg::CH_LF);
    assign is_digit = rx_byte inside {[mudf_pkg::CH_0:mudf_pkg::CH_9]};

    // header compare against all three patterns at the current position
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            match_now[k] = match_reg[k]
                && (mudf_pkg::HDR_TAB[k][(mudf_pkg::HDR_LEN - 1 - int'(hpos_reg))*8 +: 8]
                    == rx_byte);
        end
    end

    // decimal accumulate with saturation
    assign len_x10 = ({4'b0, len_reg} << 3) + ({4'b0, len_reg} << 1)
                   + (mudf_pkg::LEN_W+4)'(rx_byte[3:0]);
    assign len_acc = (len_x10 > (mudf_pkg::LEN_W+4)'(mudf_pkg::LEN_SAT))
                   ? mudf_pkg::LEN_SAT : len_x10[mudf_pkg::LEN_W-1:0];
    assign len_dec = (len_reg != '0) ? len_reg - mudf_pkg::LEN_W'(1) : len_reg;

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (take && (cmd == mudf_pkg::CMD_FLUSH))
            phase_next = mudf_pkg::PH_SEARCH;
        else if (rx_take)
        begin
            case (phase_reg)
                mudf_pkg::PH_SEARCH:
                    if (rx_byte == mudf_pkg::CH_PLUS)
                        phase_next = mudf_pkg::PH_HEADER;
                mudf_pkg::PH_HEADER:
                    if (hdr_last)
                    begin
                        if (match_now[0])
                            phase_next = mudf_pkg::PH_SKIP_ID;
                        else if (match_now[1])
                            phase_next = mudf_pkg::PH_READ_LEN;
                        else
                            phase_next = mudf_pkg::PH_SEARCH;
                    end
                mudf_pkg::PH_SKIP_ID:
                    if (rx_byte == mudf_pkg::CH_COMMA)
                        phase_next = mudf_pkg::PH_READ_LEN;
                mudf_pkg::PH_READ_LEN:
                    if (is_term)
                        phase_next = (len_reg != '0) ? mudf_pkg::PH_READ_DATA
                                                     : mudf_pkg::PH_SEARCH;
                mudf_pkg::PH_READ_DATA:
                    if (len_dec == '0)
                        phase_next = mudf_pkg::PH_SEARCH;
                default:
                    phase_next = mudf_pkg::PH_SEARCH;
            endcase
        end
    end

    // datapath updates per phase
    always_comb
    begin
        hpos_next  = hpos_reg;
        match_next = match_reg;
        len_next   = len_reg;
        dig_next   = dig_reg;
        pend_next  = pend_reg;
        push_next  = push_reg;
        wr.en      = 1'b0;
        wr.data    = rx_byte;
        if (take && (cmd == mudf_pkg::CMD_FLUSH))
        begin
            hpos_next  = '0;
            match_next = 3'b111;
            len_next   = '0;
            dig_next   = '0;
            pend_next  = 1'b0;
            push_next  = 1'b0;
        end
        else if (take && (cmd == mudf_pkg::CMD_ACK))
            push_next = 1'b0;
        else if (rx_take)
        begin
            case (phase_reg)
                mudf_pkg::PH_SEARCH:
                    if (rx_byte == mudf_pkg::CH_PLUS)
                    begin
                        hpos_next  = '0;
                        match_next = 3'b111;
                    end
                mudf_pkg::PH_HEADER:
                    if (hdr_last)
                    begin
                        hpos_next  = '0;
                        match_next = 3'b111;
                        if (!match_now[0] && match_now[1])
                        begin
                            len_next = '0;
                            dig_next = '0;
                        end
                        else if (!match_now[0] && !match_now[1] && match_now[2])
                            push_next = 1'b1;
                    end
                    else
                    begin
                        hpos_next  = hpos_reg + mudf_pkg::HPOS_W'(1);
                        match_next = match_now;
                    end
                mudf_pkg::PH_SKIP_ID:
                    if (rx_byte == mudf_pkg::CH_COMMA)
                    begin
                        len_next = '0;
                        dig_next = '0;
                    end
                mudf_pkg::PH_READ_LEN:
                    if (is_term)
                    begin
                        pend_next = (len_reg != '0);
                        dig_next  = '0;
                    end
                    else if (is_digit && (dig_reg < mudf_pkg::DIG_W'(mudf_pkg::MAX_DIGITS)))
                    begin
                        len_next = len_acc;
                        dig_next = dig_reg + mudf_pkg::DIG_W'(1);
                    end
                mudf_pkg::PH_READ_DATA:
                begin
                    wr.en    = (len_reg != '0);
                    len_next = len_dec;
                end
                default:
                    len_next = len_reg;
            endcase
        end
    end

    assign flags.pending = pend_next;
    assign flags.push    = push_next;

    // parser registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= mudf_pkg::PH_SEARCH;
            hpos_reg  <= '0;
            match_reg <= 3'b111;
            len_reg   <= '0;
            dig_reg   <= '0;
            pend_reg  <= 1'b0;
            push_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            hpos_reg  <= hpos_next;
            match_reg <= match_next;
            len_reg   <= len_next;
            dig_reg   <= dig_next;
            pend_reg  <= pend_next;
            push_reg  <= push_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/modem_urc_payload_deframer.sv */
`default_nettype none

// channel  modport  word contents
// req      sink     cmd (2b), rx_byte (8b)
// rsp      source   pop_valid, pop_byte (8b), payload_pending, read_request_needed
//
// every command word yields one result word, passed through the read stage and the output register
// one word per cycle sustained while rsp.ready stays high; pops read the
// payload ram through its registered read port
// rst_n clears parser, pointers and flags; ram contents are not cleared
// a result may sit in the output register while the next word is taken;
// req.ready drops only when both the read stage and the output register are full

module modem_urc_payload_deframer (
    input  wire logic  clk,
    input  wire logic  rst_n,
    mudf_req_if.sink   req,
    mudf_rsp_if.source rsp
);

    logic                        accept;
    logic                        s1_move;
    mudf_pkg::wr_req_t           wr;
    mudf_pkg::flags_t            flags;

    logic [mudf_pkg::ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [mudf_pkg::ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic                        mem_we;
    logic                        mem_re;
    logic [7:0]                  mem_rdata;

    logic                        s1_valid_reg, s1_valid_next;
    logic                        s1_pv_reg;
    mudf_pkg::flags_t            s1_flags_reg;

    logic                        out_valid_reg, out_valid_next;
    logic                        out_pv_reg;
    logic [7:0]                  out_byte_reg;
    mudf_pkg::flags_t            out_flags_reg;

    // handshake
    assign s1_move   = !out_valid_reg || rsp.ready;
    assign req.ready = !s1_valid_reg || s1_move;
    assign accept    = req.valid && req.ready;

    mudf_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (accept),
        .cmd     (req.cmd),
        .rx_byte (req.rx_byte),
        .wr      (wr),
        .flags   (flags)
    );

    // ring pointer control
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        if (accept)
        begin
            case (req.cmd)
                mudf_pkg::CMD_RX:
                    if (wr.en && (mudf_pkg::ptr_inc(wr_ptr_reg) != rd_ptr_reg))
                    begin
                        mem_we      = 1'b1;
                        wr_ptr_next = mudf_pkg::ptr_inc(wr_ptr_reg);
                    end
                mudf_pkg::CMD_POP:
                    if (wr_ptr_reg != rd_ptr_reg)
                    begin
                        mem_re      = 1'b1;
                        rd_ptr_next = mudf_pkg::ptr_inc(rd_ptr_reg);
                    end
                mudf_pkg::CMD_FLUSH:
                begin
                    wr_ptr_next = '0;
                    rd_ptr_next = '0;
                end
                default:
                    wr_ptr_next = wr_ptr_reg;
            endcase
        end
    end

    mudf_ram #(
        .DEPTH (mudf_pkg::BUF_DEPTH),
        .WIDTH (8)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (wr_ptr_reg),
        .wdata (wr.data),
        .re    (mem_re),
        .raddr (rd_ptr_reg),
        .rdata (mem_rdata)
    );

    // stage valid bits
    always_comb
    begin
        s1_valid_next  = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
        out_valid_next = out_valid_reg;
        if (s1_valid_reg && s1_move)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // read stage and output register payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pv_reg    <= mem_re;
            s1_flags_reg <= flags;
        end
        if (s1_valid_reg && s1_move)
        begin
            out_pv_reg    <= s1_pv_reg;
            out_byte_reg  <= s1_pv_reg ? mem_rdata : 8'h00;
            out_flags_reg <= s1_flags_reg;
        end
    end

    assign rsp.valid               = out_valid_reg;
    assign rsp.pop_valid           = out_pv_reg;
    assign rsp.pop_byte            = out_byte_reg;
    assign rsp.payload_pending     = out_flags_reg.pending;
    assign rsp.read_request_needed = out_flags_reg.push;

    // a write never leaves the ring looking empty
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> (wr_ptr_reg != rd_ptr_reg))
        else $error("ring write made pointers equal");

    // flush returns both pointers to zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.cmd == mudf_pkg::CMD_FLUSH)) |=> (wr_ptr_reg == '0 && rd_ptr_reg == '0))
        else $error("flush did not clear pointers");

    // a stalled popped word keeps its read data
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_pv_reg && !s1_move) |=> (s1_valid_reg && $stable(mem_rdata)))
        else $error("read stage lost a stalled word");

    // a successful pop reaches the read stage marked valid
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |=> (s1_valid_reg && s1_pv_reg))
        else $error("pop result missing from read stage");

    // ram is never written and read in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("ram write and read overlap");

endmodule

`default_nettype wire

/* dv/modem_urc_payload_deframer_tb.sv */
`timescale 1ns / 1ps

module modem_urc_payload_deframer_tb;

    // status word returned for every command word
    typedef struct packed {
        logic       pop_valid;
        logic [7:0] pop_byte;
        logic       payload_pending;
        logic       read_request_needed;
    } urc_status_t;

    // kinds of traffic the random part builds
    typedef enum int {
        FR_TCP,
        FR_READ,
        FR_PUSH,
        FR_BAD_HDR,
        FR_NOISE
    } frame_kind_t;

    // deframer prediction and status checking
    class urc_scoreboard;
        mudf_pkg::phase_t phase;
        int unsigned      hdr_pos;
        logic [2:0]       hdr_match;
        int unsigned      len_left;
        int unsigned      digits;
        logic [7:0]       ring [mudf_pkg::BUF_DEPTH];
        int unsigned      wr_ptr;
        int unsigned      rd_ptr;
        bit               pending;
        bit               push_seen;
        string            hdr_names [3];
        urc_status_t      status_due [$];
        int               errors;
        int               words;
        int               pops_hit;
        int               pops_empty;
        int               dropped;
        int               lengths_taken;

        function new();
            hdr_names = '{"MIPRTCP:", "MIPREAD:", "MIPPUSH:"};
            errors = 0;
            words = 0;
            pops_hit = 0;
            pops_empty = 0;
            dropped = 0;
            lengths_taken = 0;
            clear_parser();
        endfunction

        // flush and reset: everything but the ring contents
        function void clear_parser();
            phase = mudf_pkg::PH_SEARCH;
            hdr_pos = 0;
            hdr_match = 3'b111;
            len_left = 0;
            digits = 0;
            wr_ptr = 0;
            rd_ptr = 0;
            pending = 1'b0;
            push_seen = 1'b0;
        endfunction

        function void open_length();
            phase = mudf_pkg::PH_READ_LEN;
            len_left = 0;
            digits = 0;
        endfunction

        // one received serial byte through the parser
        function void take_rx(logic [7:0] b);
            longint unsigned acc;
            int unsigned     nxt;
            case (phase)
                mudf_pkg::PH_SEARCH:
                begin
                    if (b == mudf_pkg::CH_PLUS)
                    begin
                        phase = mudf_pkg::PH_HEADER;
                        hdr_pos = 0;
                        hdr_match = 3'b111;
                    end
                end
                mudf_pkg::PH_HEADER:
                begin
                    for (int k = 0; k < 3; k++)
                        if (hdr_names[k][hdr_pos] != b)
                            hdr_match[k] = 1'b0;
                    hdr_pos++;
                    if (hdr_pos >= mudf_pkg::HDR_LEN)
                    begin
                        hdr_pos = 0;
                        if (hdr_match[0])
                            phase = mudf_pkg::PH_SKIP_ID;
                        else if (hdr_match[1])
                            open_length();
                        else
                        begin
                            if (hdr_match[2])
                                push_seen = 1'b1;
                            phase = mudf_pkg::PH_SEARCH;
                        end
                        hdr_match = 3'b111;
                    end
                end
                mudf_pkg::PH_SKIP_ID:
                begin
                    if (b == mudf_pkg::CH_COMMA)
                        open_length();
                end
                mudf_pkg::PH_READ_LEN:
                begin
                    if (b == mudf_pkg::CH_COMMA || b == mudf_pkg::CH_CR
                        || b == mudf_pkg::CH_LF)
                    begin
                        if (len_left > 0)
                        begin
                            phase = mudf_pkg::PH_READ_DATA;
                            pending = 1'b1;
                            lengths_taken++;
                        end
                        else
                        begin
                            pending = 1'b0;
                            phase = mudf_pkg::PH_SEARCH;
                        end
                        digits = 0;
                    end
                    else if (b >= mudf_pkg::CH_0 && b <= mudf_pkg::CH_9)
                    begin
                        if (digits < mudf_pkg::MAX_DIGITS)
                        begin
                            acc = longint'(len_left) * 10 + longint'(b)
                                - longint'(mudf_pkg::CH_0);
                            len_left = (acc > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : acc[31:0];
                            digits++;
                        end
                    end
                end
                mudf_pkg::PH_READ_DATA:
                begin
                    if (len_left > 0)
                    begin
                        nxt = (wr_ptr + 1) % mudf_pkg::BUF_DEPTH;
                        if (nxt != rd_ptr)
                        begin
                            ring[wr_ptr] = b;
                            wr_ptr = nxt;
                        end
                        else
                            dropped++;
                        len_left--;
                    end
                    if (len_left == 0)
                        phase = mudf_pkg::PH_SEARCH;
                end
                default:
                    phase = mudf_pkg::PH_SEARCH;
            endcase
        endfunction

        // accepted command word: advance state, queue the status it yields
        function void note_word(mudf_pkg::cmd_t c, logic [7:0] b);
            urc_status_t st;
            st = '0;
            words++;
            case (c)
                mudf_pkg::CMD_RX:
                    take_rx(b);
                mudf_pkg::CMD_POP:
                begin
                    if (wr_ptr != rd_ptr)
                    begin
                        st.pop_valid = 1'b1;
                        st.pop_byte = ring[rd_ptr];
                        rd_ptr = (rd_ptr + 1) % mudf_pkg::BUF_DEPTH;
                        pops_hit++;
                    end
                    else
                        pops_empty++;
                end
                mudf_pkg::CMD_ACK:
                    push_seen = 1'b0;
                mudf_pkg::CMD_FLUSH:
                    clear_parser();
                default:
                    clear_parser();
            endcase
            st.payload_pending = pending;
            st.read_request_needed = push_seen;
            status_due.push_back(st);
        endfunction

        // accepted result word against the oldest prediction
        function void check_status(urc_status_t got);
            urc_status_t want;
            if (status_due.size() == 0)
            begin
                errors++;
                if (errors <= 100)
                    $display("%0t: unexpected result word pv=%0d byte=%02h pend=%0d rrn=%0d",
                             $time, got.pop_valid, got.pop_byte, got.payload_pending,
                             got.read_request_needed);
                return;
            end
            want = status_due.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 100)
                    $display("%0t: mismatch expected pv=%0d byte=%02h pend=%0d rrn=%0d, %s",
                             $time, want.pop_valid, want.pop_byte, want.payload_pending,
                             want.read_request_needed,
                             $sformatf("actual pv=%0d byte=%02h pend=%0d rrn=%0d",
                                       got.pop_valid, got.pop_byte, got.payload_pending,
                                       got.read_request_needed));
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    mudf_req_if req_ch ();
    mudf_rsp_if rsp_ch ();

    urc_scoreboard sb;

    int source_idle_pct;
    int sink_stall_pct;
    int words_sent;

    modem_urc_payload_deframer u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard stop
    initial
    begin
        #50_000_000;
        $display("timeout with %0d result words outstanding", sb.status_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // result side: check accepted words, stall at random
    initial
    begin
        urc_status_t got;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                got.pop_valid = rsp_ch.pop_valid;
                got.pop_byte = rsp_ch.pop_byte;
                got.payload_pending = rsp_ch.payload_pending;
                got.read_request_needed = rsp_ch.read_request_needed;
                sb.check_status(got);
            end
            rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // one command word, with random idle cycles ahead of it
    task automatic send_word(mudf_pkg::cmd_t c, logic [7:0] b);
        while ($urandom_range(99) < source_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd <= c;
        req_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_word(c, b);
        words_sent++;
    endtask

    task automatic rx(logic [7:0] b);
        send_word(mudf_pkg::CMD_RX, b);
    endtask

    task automatic rx_text(string s);
        for (int i = 0; i < s.len(); i++)
            rx(s[i]);
    endtask

    task automatic pop_n(int n);
        for (int i = 0; i < n; i++)
            send_word(mudf_pkg::CMD_POP, 8'($urandom_range(255)));
    endtask

    // hold the sender until every result word is back
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.status_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // byte that is neither a digit nor a length terminator
    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(255));
        while ((b >= mudf_pkg::CH_0 && b <= mudf_pkg::CH_9) || b == mudf_pkg::CH_COMMA
               || b == mudf_pkg::CH_CR || b == mudf_pkg::CH_LF);
        return b;
    endfunction

    // decimal length text, stray bytes mixed in now and then
    task automatic send_length(string txt);
        for (int i = 0; i < txt.len(); i++)
        begin
            if ($urandom_range(99) < 10)
                rx(junk_byte());
            rx(txt[i]);
        end
        case ($urandom_range(2))
            0: rx(mudf_pkg::CH_COMMA);
            1: rx(mudf_pkg::CH_CR);
            default: rx(mudf_pkg::CH_LF);
        endcase
    endtask

    // one notification, well formed or broken
    task automatic send_frame(frame_kind_t kind);
        string      hdr;
        string      len_txt;
        int         n_data;
        int         bad_pos;
        int         roll;
        bit         cut_off;
        logic [7:0] b;
        cut_off = 1'b0;
        n_data = 0;
        // plain noise bytes, biased towards parser characters
        if (kind == FR_NOISE)
        begin
            repeat ($urandom_range(1, 6))
            begin
                case ($urandom_range(4))
                    0: rx(mudf_pkg::CH_PLUS);
                    1: rx(mudf_pkg::CH_COMMA);
                    2: rx(8'(mudf_pkg::CH_0 + $urandom_range(9)));
                    default: rx(8'($urandom_range(255)));
                endcase
            end
            return;
        end
        case (kind)
            FR_TCP: hdr = "MIPRTCP:";
            FR_PUSH: hdr = "MIPPUSH:";
            FR_READ: hdr = "MIPREAD:";
            default: hdr = sb.hdr_names[$urandom_range(2)];
        endcase
        bad_pos = $urandom_range(7);
        rx(mudf_pkg::CH_PLUS);
        for (int i = 0; i < mudf_pkg::HDR_LEN; i++)
        begin
            b = hdr[i];
            if (kind == FR_BAD_HDR && i == bad_pos)
                b = b ^ 8'($urandom_range(1, 255));
            rx(b);
        end
        if (kind == FR_PUSH || kind == FR_BAD_HDR)
            return;
        // link id ahead of the comma
        if (kind == FR_TCP)
        begin
            repeat ($urandom_range(0, 3))
            begin
                if ($urandom_range(3) == 0)
                    rx(junk_byte());
                else
                    rx(8'(mudf_pkg::CH_0 + $urandom_range(9)));
            end
            rx(mudf_pkg::CH_COMMA);
        end
        // length text
        roll = $urandom_range(99);
        if (roll < 4)
        begin
            case ($urandom_range(3))
                0: len_txt = "99999999999";
                1: len_txt = "2147483648";
                2: len_txt = "4294967296";
                default: len_txt = "2147483647";
            endcase
            n_data = $urandom_range(0, 5);
            cut_off = 1'b1;
        end
        else if (roll < 8)
        begin
            // eleven digits, the last one beyond the digit limit
            n_data = $urandom_range(0, 9);
            len_txt = $sformatf("000000000%0d%0d", n_data, $urandom_range(9));
        end
        else if (roll < 18)
        begin
            case ($urandom_range(2))
                0: len_txt = "";
                1: len_txt = "0";
                default: len_txt = "000";
            endcase
        end
        else
        begin
            n_data = $urandom_range(1, 24);
            len_txt = $sformatf("%0d", n_data);
            if ($urandom_range(4) == 0)
                len_txt = {"0", len_txt};
        end
        send_length(len_txt);
        // payload, sometimes interleaved with pops or broken off
        for (int i = 0; i < n_data; i++)
        begin
            if ($urandom_range(99) < 8)
                pop_n(1);
            if ($urandom_range(99) < 3)
            begin
                send_word(mudf_pkg::CMD_FLUSH, 8'($urandom_range(255)));
                return;
            end
            rx(8'($urandom_range(255)));
        end
        if (cut_off)
            send_word(mudf_pkg::CMD_FLUSH, 8'($urandom_range(255)));
    endtask

    // mixed notifications, pops and acknowledges
    task automatic random_traffic(int n_words);
        int start_cnt;
        int roll;
        start_cnt = words_sent;
        while (words_sent - start_cnt < n_words)
        begin
            roll = $urandom_range(99);
            if (roll < 35)
                send_frame(FR_READ);
            else if (roll < 65)
                send_frame(FR_TCP);
            else if (roll < 75)
                send_frame(FR_PUSH);
            else if (roll < 85)
                send_frame(FR_BAD_HDR);
            else
                send_frame(FR_NOISE);
            pop_n($urandom_range(0, 12));
            if ($urandom_range(99) < 20)
                send_word(mudf_pkg::CMD_ACK, 8'($urandom_range(255)));
            if ($urandom_range(99) < 3)
                send_word(mudf_pkg::CMD_FLUSH, 8'($urandom_range(255)));
        end
    endtask

    // stimulus
    initial
    begin
        sb = new();
        source_idle_pct = 0;
        sink_stall_pct = 0;
        words_sent = 0;
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.cmd = mudf_pkg::CMD_RX;
        req_ch.rx_byte = 8'h00;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extreme payload bytes, pop past empty, push and ack, flush
        rx_text("+MIPREAD:2\n");
        rx(8'h00);
        rx(8'hFF);
        pop_n(3);
        rx_text("+MIPPUSH:");
        send_word(mudf_pkg::CMD_ACK, 8'hFF);
        send_word(mudf_pkg::CMD_FLUSH, 8'hA5);
        wait_drained();

        // two payloads queued back to back, then drained past empty
        rx_text("+MIPREAD:40\r");
        repeat (40) rx(8'($urandom_range(255)));
        pop_n(20);
        rx_text("+MIPRTCP:1,40,");
        repeat (40) rx(8'($urandom_range(255)));
        pop_n(70);
        send_word(mudf_pkg::CMD_FLUSH, 8'h00);
        wait_drained();

        // random traffic under four idle and stall mixes
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: begin source_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin source_idle_pct = 75; sink_stall_pct = 0;  end
                2: begin source_idle_pct = 0;  sink_stall_pct = 75; end
                default: begin source_idle_pct = 32; sink_stall_pct = 32; end
            endcase
            random_traffic(500);
            wait_drained();
        end

        // let any late word show up
        sink_stall_pct = 0;
        repeat (20) @(posedge clk);

        $display("run covered %0d command words: %0d bytes popped, %0d pops on an empty ring",
                 sb.words, sb.pops_hit, sb.pops_empty);
        $display("%0d payload lengths taken, %0d bytes dropped on a full ring, %0d failures",
                 sb.lengths_taken, sb.dropped, sb.errors + sb.status_due.size());
        if (sb.errors == 0 && sb.status_due.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
